@@ rtl/core/rt3_pkg.sv @@
// ----------------------------------------------------------------------------
// rt3_pkg - shared types and constants of the 3D rigid transform
// Function codes, configuration register indexes and the axis count.
// ----------------------------------------------------------------------------
package rt3_pkg;

  localparam int NUM_AXES        = 3;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int FUNC_WIDTH      = 2;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_POSITION     = 2'd0,
    FUNC_DIRECTION    = 2'd1,
    FUNC_INV_POSITION = 2'd2,
    FUNC_INV_DIRECTION = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_MATRIX_ROW0 = 3'd0,
    CFG_MATRIX_ROW1 = 3'd1,
    CFG_MATRIX_ROW2 = 3'd2,
    CFG_SHIFT_X     = 3'd3,
    CFG_SHIFT_Y     = 3'd4,
    CFG_SHIFT_Z     = 3'd5
  } cfg_index_t;

endpackage

@@ rtl/core/rt3_if.sv @@
// ----------------------------------------------------------------------------
// rt3_if - channel interfaces of the 3D rigid transform
// Input vector channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rt3_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                                   valid;
  logic                                   ready;
  logic [rt3_pkg::FUNC_WIDTH-1:0]         func;
  logic signed [COORD_WIDTH-1:0]          vec_x;
  logic signed [COORD_WIDTH-1:0]          vec_y;
  logic signed [COORD_WIDTH-1:0]          vec_z;

  modport source (output valid, func, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, func, vec_x, vec_y, vec_z, output ready);
endinterface

interface rt3_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] res_x;
  logic signed [COORD_WIDTH-1:0] res_y;
  logic signed [COORD_WIDTH-1:0] res_z;
  logic                          saturated;

  modport source (output valid, res_x, res_y, res_z, saturated, input ready);
  modport sink   (input valid, res_x, res_y, res_z, saturated, output ready);
endinterface

interface rt3_cfg_if #(
  parameter int DATA_WIDTH = 48
);
  logic                                valid;
  logic                                ready;
  logic [rt3_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [DATA_WIDTH-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/rt3_lane.sv @@
// ----------------------------------------------------------------------------
// rt3_lane - one output component of the transform
// Three coefficient products, then their exact sum with the scaled offset.
// ----------------------------------------------------------------------------
module rt3_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [COEF_WIDTH-1:0]          coef [rt3_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH:0]           vec  [rt3_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]         offset,
  output logic signed [COEF_WIDTH+COORD_WIDTH+2:0] acc
);

  localparam int FRAC_SHIFT = COEF_WIDTH - 2;
  localparam int PW         = COEF_WIDTH + COORD_WIDTH + 1;
  localparam int AW         = COEF_WIDTH + COORD_WIDTH + 3;

  logic signed [PW-1:0]          prod_r   [rt3_pkg::NUM_AXES];
  logic signed [PW-1:0]          prod_nxt [rt3_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] offset_r;
  logic signed [AW-1:0]          acc_r;
  logic signed [AW-1:0]          acc_nxt;

  always_comb begin
    for (int j = 0; j < rt3_pkg::NUM_AXES; j++) begin
      prod_nxt[j] = PW'(coef[j]) * PW'(vec[j]);
    end
  end

  // offset enters at the product scale, so the sum stays exact
  always_comb begin
    acc_nxt = AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2])
            + (AW'(offset_r) <<< FRAC_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      offset_r <= offset;
      acc_r    <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/rt3_merge.sv @@
// ----------------------------------------------------------------------------
// rt3_merge - scale, saturate and combine the lane sums
// Arithmetic right shift, clip to the coordinate range, OR of clip flags.
// ----------------------------------------------------------------------------
module rt3_merge #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [COEF_WIDTH+COORD_WIDTH+2:0] acc [rt3_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]            res [rt3_pkg::NUM_AXES],
  output logic                                     saturated
);

  localparam int FRAC_SHIFT = COEF_WIDTH - 2;
  localparam int AW         = COEF_WIDTH + COORD_WIDTH + 3;
  localparam int SW         = AW - FRAC_SHIFT;
  localparam int TW         = SW - COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] res_r   [rt3_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] res_nxt [rt3_pkg::NUM_AXES];
  logic                          sat_r;
  logic                          sat_nxt;
  logic [SW-1:0]                 scaled  [rt3_pkg::NUM_AXES];
  logic [TW-1:0]                 top_bits[rt3_pkg::NUM_AXES];

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < rt3_pkg::NUM_AXES; i++) begin
      scaled[i]   = acc[i][AW-1:FRAC_SHIFT];
      top_bits[i] = scaled[i][SW-1:COORD_WIDTH-1];
      if ((&top_bits[i]) || !(|top_bits[i])) begin
        res_nxt[i] = scaled[i][COORD_WIDTH-1:0];
      end else begin
        sat_nxt = 1'b1;
        res_nxt[i] = scaled[i][SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                     : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res       = res_r;
  assign saturated = sat_r;

endmodule

@@ rtl/core/rigid_transform_3d.sv @@
// ----------------------------------------------------------------------------
// rigid_transform_3d - 3x3 rotation plus translation on Q16.16 vectors
//
//   channel  dir   payload                          handshake
//   in_ch    in    func, vec_x, vec_y, vec_z        valid/ready
//   out_ch   out   res_x, res_y, res_z, saturated   valid/ready
//   cfg_ch   in    index, data                      valid/ready (ready = 1)
//
// One vector per cycle while no result waits; a result passes through the operand select,
// product, lane sum and saturation registers in that order.
// The whole pipeline advances together; it holds while a result waits.
// rst_n clears valid bits and loads the identity matrix, zero translation.
// Inverse position is computed as transpose(R) * (v - t), exact.
// ----------------------------------------------------------------------------
module rigid_transform_3d #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input logic        clk,
  input logic        rst_n,
  rt3_in_if.sink     in_ch,
  rt3_out_if.source  out_ch,
  rt3_cfg_if.sink    cfg_ch
);

  localparam int NA         = rt3_pkg::NUM_AXES;
  localparam int FRAC_SHIFT = COEF_WIDTH - 2;
  localparam int RW         = 3 * COEF_WIDTH;
  localparam int AW         = COEF_WIDTH + COORD_WIDTH + 3;

  // configuration
  logic [RW-1:0]                 row_r   [NA];
  logic signed [COORD_WIDTH-1:0] shift_r [NA];

  // stage 1: operand select
  logic                          s1_valid_r;
  logic signed [COEF_WIDTH-1:0]  coef_r   [NA][NA];
  logic signed [COEF_WIDTH-1:0]  coef_nxt [NA][NA];
  logic signed [COORD_WIDTH:0]   vec_r    [NA];
  logic signed [COORD_WIDTH:0]   vec_nxt  [NA];
  logic signed [COORD_WIDTH-1:0] off_r    [NA];
  logic signed [COORD_WIDTH-1:0] off_nxt  [NA];

  logic                          s2_valid_r;
  logic                          s3_valid_r;
  logic                          out_valid_r;
  logic                          pipe_en;
  logic                          in_fire;
  logic                          out_fire;
  rt3_pkg::func_t                func;
  logic                          inverse;
  logic signed [COORD_WIDTH-1:0] vin [NA];
  logic signed [AW-1:0]          lane_acc [NA];
  logic signed [COORD_WIDTH-1:0] res [NA];
  logic                          saturated;

  assign pipe_en  = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && pipe_en;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready  = pipe_en;
  assign cfg_ch.ready = 1'b1;

  // ---------------- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        row_r[i]   <= RW'(1) << (i * COEF_WIDTH + FRAC_SHIFT);
        shift_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (rt3_pkg::cfg_index_t'(cfg_ch.index))
        rt3_pkg::CFG_MATRIX_ROW0: row_r[0]   <= cfg_ch.data[RW-1:0];
        rt3_pkg::CFG_MATRIX_ROW1: row_r[1]   <= cfg_ch.data[RW-1:0];
        rt3_pkg::CFG_MATRIX_ROW2: row_r[2]   <= cfg_ch.data[RW-1:0];
        rt3_pkg::CFG_SHIFT_X:     shift_r[0] <= cfg_ch.data[COORD_WIDTH-1:0];
        rt3_pkg::CFG_SHIFT_Y:     shift_r[1] <= cfg_ch.data[COORD_WIDTH-1:0];
        rt3_pkg::CFG_SHIFT_Z:     shift_r[2] <= cfg_ch.data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1
  assign func    = rt3_pkg::func_t'(in_ch.func);
  assign inverse = (func == rt3_pkg::FUNC_INV_POSITION) ||
                   (func == rt3_pkg::FUNC_INV_DIRECTION);
  assign vin[0]  = in_ch.vec_x;
  assign vin[1]  = in_ch.vec_y;
  assign vin[2]  = in_ch.vec_z;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NA; j++) begin
        coef_nxt[i][j] = inverse ? row_r[j][i*COEF_WIDTH +: COEF_WIDTH]
                                 : row_r[i][j*COEF_WIDTH +: COEF_WIDTH];
      end
      if (func == rt3_pkg::FUNC_INV_POSITION) begin
        vec_nxt[i] = (COORD_WIDTH+1)'(vin[i]) - (COORD_WIDTH+1)'(shift_r[i]);
      end else begin
        vec_nxt[i] = (COORD_WIDTH+1)'(vin[i]);
      end
      off_nxt[i] = (func == rt3_pkg::FUNC_POSITION) ? shift_r[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      coef_r <= coef_nxt;
      vec_r  <= vec_nxt;
      off_r  <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- lanes, one per output component
  for (genvar g = 0; g < NA; g++) begin : g_lane
    rt3_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_lane (
      .clk    (clk),
      .en     (pipe_en),
      .coef   (coef_r[g]),
      .vec    (vec_r),
      .offset (off_r[g]),
      .acc    (lane_acc[g])
    );
  end

  rt3_merge #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_merge (
    .clk       (clk),
    .en        (pipe_en),
    .acc       (lane_acc),
    .res       (res),
    .saturated (saturated)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_x     = res[0];
  assign out_ch.res_y     = res[1];
  assign out_ch.res_z     = res[2];
  assign out_ch.saturated = saturated;

  // ---------------- assertions
  localparam logic signed [COORD_WIDTH-1:0] RES_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] RES_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transaction did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable({s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r}))
    else $error("pipeline moved during a stall");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while result is stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !s3_valid_r) |=> !out_valid_r)
    else $error("result repeated after its transaction");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && saturated) |->
      (res[0] == RES_MAX || res[0] == RES_MIN ||
       res[1] == RES_MAX || res[1] == RES_MIN ||
       res[2] == RES_MAX || res[2] == RES_MIN))
    else $error("saturated flag without a clipped component");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking testbench for rigid_transform_3d
// A queue-fed driver offers vectors with random gaps, a monitor predicts
// every accepted transaction and checks each result field against it.
// Configuration is rewritten between phases: identity, extreme and random
// matrices and translations, plus writes to unused register indexes.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_W        = 32;
  localparam int COEF_W         = 16;
  localparam int FRAC_BITS      = COEF_W - 2;
  localparam int ROW_W          = 3 * COEF_W;
  localparam int PIPE_SETTLE    = 8;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 136;

  localparam logic [rt3_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [rt3_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_HI = 3'd7;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct {
    rt3_pkg::func_t            op;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
  } vec_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      sat;
  } vec_result_t;

  logic clk;
  logic rst_n;

  rt3_in_if  #(.COORD_WIDTH(COORD_W)) in_ch ();
  rt3_out_if #(.COORD_WIDTH(COORD_W)) out_ch ();
  rt3_cfg_if #(.DATA_WIDTH(ROW_W))    cfg_ch ();

  rigid_transform_3d #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (COEF_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor copy of the register file
  logic [ROW_W-1:0]          mat_row [3];
  logic signed [COORD_W-1:0] trans   [3];

  vec_item_t   pending_vecs[$];
  vec_result_t predicted_results[$];
  vec_item_t   drv_vec;

  logic vec_taken;
  logic in_idle_en;
  logic out_idle_en;
  logic long_hold_req;
  int   in_gap;
  int   out_hold;
  int   errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [COEF_W-1:0] coef(int r, int c);
    return mat_row[r][c*COEF_W +: COEF_W];
  endfunction

  function automatic vec_result_t transform_vec(vec_item_t it);
    logic signed [63:0]        acc, rt, cw, vw, tw, shifted;
    logic signed [COORD_W-1:0] v   [3];
    logic signed [COORD_W-1:0] res [3];
    logic                      inverse, position, clip;
    vec_result_t               r;
    v[0] = it.vx;
    v[1] = it.vy;
    v[2] = it.vz;
    inverse  = (it.op == rt3_pkg::FUNC_INV_POSITION) ||
               (it.op == rt3_pkg::FUNC_INV_DIRECTION);
    position = (it.op == rt3_pkg::FUNC_POSITION) ||
               (it.op == rt3_pkg::FUNC_INV_POSITION);
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        cw = inverse ? coef(j, i) : coef(i, j);
        vw = v[j];
        acc += cw * vw;
      end
      if (position && !inverse) begin
        tw = trans[i];
        acc += tw <<< FRAC_BITS;
      end else if (position) begin
        // subtract transpose(R) * t, kept exact
        rt = '0;
        for (int j = 0; j < 3; j++) begin
          cw = coef(j, i);
          tw = trans[j];
          rt += cw * tw;
        end
        acc -= rt;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
        res[i] = C_MAX;
        clip = 1'b1;
      end else if (shifted < SAT_LO) begin
        res[i] = C_MIN;
        clip = 1'b1;
      end else begin
        res[i] = shifted[COORD_W-1:0];
      end
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    r.sat = clip;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return int'($urandom_range(0, 2097151)) - 1048576;
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(int style, int r);
    logic [ROW_W-1:0] row;
    int               c_val;
    row = '0;
    case (style)
      0: row = ROW_W'({$urandom, $urandom});
      1: begin
        for (int c = 0; c < 3; c++) begin
          c_val = int'($urandom_range(0, 32768)) - 16384;
          row[c*COEF_W +: COEF_W] = c_val[COEF_W-1:0];
        end
      end
      default: row[r*COEF_W +: COEF_W] = 16'sd16384;
    endcase
    return row;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_shift(int style);
    case (style)
      0: return $urandom;
      1: return int'($urandom_range(0, 8388607)) - 4194304;
      default: return '0;
    endcase
  endfunction

  function automatic void push_vec(rt3_pkg::func_t op, logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y,
                                   logic signed [COORD_W-1:0] z);
    vec_item_t it;
    it.op = op;
    it.vx = x;
    it.vy = y;
    it.vz = z;
    pending_vecs.push_back(it);
  endfunction

  task automatic check_field(string name, logic signed [COORD_W-1:0] want,
                             logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic write_reg(logic [rt3_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           logic [ROW_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      rt3_pkg::CFG_MATRIX_ROW0: mat_row[0] = data;
      rt3_pkg::CFG_MATRIX_ROW1: mat_row[1] = data;
      rt3_pkg::CFG_MATRIX_ROW2: mat_row[2] = data;
      rt3_pkg::CFG_SHIFT_X:     trans[0] = data[COORD_W-1:0];
      rt3_pkg::CFG_SHIFT_Y:     trans[1] = data[COORD_W-1:0];
      rt3_pkg::CFG_SHIFT_Z:     trans[2] = data[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [ROW_W-1:0] r0, r1, r2,
                             logic signed [COORD_W-1:0] tx, ty, tz);
    write_reg(rt3_pkg::CFG_MATRIX_ROW0, r0);
    write_reg(rt3_pkg::CFG_MATRIX_ROW1, r1);
    write_reg(rt3_pkg::CFG_MATRIX_ROW2, r2);
    // junk above the translation width must be dropped
    write_reg(rt3_pkg::CFG_SHIFT_X, {16'($urandom), tx});
    write_reg(rt3_pkg::CFG_SHIFT_Y, {16'($urandom), ty});
    write_reg(rt3_pkg::CFG_SHIFT_Z, {16'($urandom), tz});
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
              ROW_W'({$urandom, $urandom}));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(pending_vecs.size() == 0 && !in_ch.valid && predicted_results.size() == 0))
      @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_ch.valid || vec_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_vecs.size() > 0) begin
        drv_vec = pending_vecs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func  <= drv_vec.op;
        in_ch.vec_x <= drv_vec.vx;
        in_ch.vec_y <= drv_vec.vy;
        in_ch.vec_z <= drv_vec.vz;
        in_gap = in_idle_en ? idle_len() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    vec_taken = 1'b0;
  end

  // result back-pressure
  always @(negedge clk) begin
    if (long_hold_req) begin
      out_hold = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_idle_en) out_hold = idle_len();
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %0d %0d %0d sat %0b",
                   $time, out_ch.res_x, out_ch.res_y, out_ch.res_z, out_ch.saturated);
        end else begin
          want = predicted_results.pop_front();
          check_field("res_x", want.x, out_ch.res_x);
          check_field("res_y", want.y, out_ch.res_y);
          check_field("res_z", want.z, out_ch.res_z);
          check_field("saturated", COORD_W'(want.sat), COORD_W'(out_ch.saturated));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(transform_vec(drv_vec));
        vec_taken = 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[rigid_transform_3d] ERROR");
    $finish;
  end

  initial begin
    rt3_pkg::func_t ops [4];
    int             row_style;
    int             shift_style;
    ops = '{rt3_pkg::FUNC_POSITION, rt3_pkg::FUNC_DIRECTION,
            rt3_pkg::FUNC_INV_POSITION, rt3_pkg::FUNC_INV_DIRECTION};
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = '0;
    in_ch.vec_x   = '0;
    in_ch.vec_y   = '0;
    in_ch.vec_z   = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    vec_taken     = 1'b0;
    in_idle_en    = 1'b0;
    out_idle_en   = 1'b0;
    long_hold_req = 1'b0;
    in_gap        = 0;
    out_hold      = 0;
    errors        = 0;
    for (int r = 0; r < 3; r++) begin
      mat_row[r] = '0;
      mat_row[r][r*COEF_W +: COEF_W] = 16'sd16384;
      trans[r] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: identity, no translation
    for (int k = 0; k < 4; k++) begin
      push_vec(ops[k], C_MAX, C_MIN, '0);
      push_vec(ops[k], -1, 1, -32'sd98765);
    end
    wait_drained();

    // largest coefficients, extreme translation: clips both ways
    load_config(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
                C_MAX, C_MIN, '0);
    for (int k = 0; k < 4; k++) begin
      push_vec(ops[k], C_MAX, C_MAX, C_MAX);
      push_vec(ops[k], C_MIN, C_MIN, C_MIN);
    end
    wait_drained();

    load_config(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                C_MIN, C_MAX, -1);
    for (int k = 0; k < 4; k++) begin
      push_vec(ops[k], C_MAX, C_MIN, 1);
      push_vec(ops[k], -1, -1, -1);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      row_style   = p % 3;
      shift_style = (p + 1) % 3;
      load_config(rand_row(row_style, 0), rand_row(row_style, 1), rand_row(row_style, 2),
                  rand_shift(shift_style), rand_shift(shift_style), rand_shift(shift_style));
      in_idle_en  = (p != 2) && (p != 5);
      out_idle_en = (p != 2);
      repeat (PHASE_ITEMS)
        push_vec(rt3_pkg::func_t'($urandom_range(0, 3)),
                 rand_coord(), rand_coord(), rand_coord());
      if (p == 5) begin
        // stall the output mid-stream while input keeps coming
        while (pending_vecs.size() > PHASE_ITEMS / 2) @(posedge clk);
        long_hold_req = 1'b1;
      end
      wait_drained();
    end

    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    wait_drained();
    if (errors == 0)
      $display("[rigid_transform_3d] OK");
    else
      $display("[rigid_transform_3d] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rt3_pkg.sv
rtl/core/rt3_if.sv
rtl/core/rt3_lane.sv
rtl/core/rt3_merge.sv
rtl/core/rigid_transform_3d.sv
tb/tb.sv
